[design/gbr_pkg.sv]
`default_nettype none
package gbr_pkg;

  localparam int PIX_W         = 8;
  localparam int RGB_W         = 3 * PIX_W;
  localparam int CFG_DIM_W     = 11;
  localparam int WT_W          = 16;
  localparam int ROW_W         = 10;
  localparam int KSIZE         = 9;
  localparam int KHALF         = 4;
  localparam int STORE_LINES   = 8;
  localparam int SLOT_W        = 3;
  localparam int MAX_HEIGHT    = 1024;
  localparam int DEF_MAX_WIDTH = 1024;
  localparam int WIN_DEPTH     = KSIZE * KSIZE;
  localparam int WIN_AW        = 7;
  localparam int KIDX_W        = 4;
  localparam int TAP_W         = 3;
  localparam int ACC_W         = 47;
  localparam int FRAC_W        = 32;
  localparam int PADDR_W       = 5;
  localparam int PDATA_W       = 32;

  typedef enum logic [2:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_W0     = 3'd2,
    REG_W1     = 3'd3,
    REG_W2     = 3'd4,
    REG_W3     = 3'd5,
    REG_W4     = 3'd6
  } reg_idx_t;

  localparam logic [CFG_DIM_W-1:0] RST_WIDTH  = 11'd640;
  localparam logic [CFG_DIM_W-1:0] RST_HEIGHT = 11'd480;
  localparam logic [WT_W-1:0]      RST_W0     = 16'd10038;
  localparam logic [WT_W-1:0]      RST_W1     = 16'd9496;
  localparam logic [WT_W-1:0]      RST_W2     = 16'd8037;
  localparam logic [WT_W-1:0]      RST_W3     = 16'd6088;
  localparam logic [WT_W-1:0]      RST_W4     = 16'd4127;

  typedef struct packed {
    logic clr;
    logic valid;
  } mac_ctrl_t;

  // distance of a kernel row or column from the center
  function automatic logic [TAP_W-1:0] tap_of(input logic [KIDX_W-1:0] k);
    logic [KIDX_W-1:0] d;
    d = (k < KIDX_W'(KHALF)) ? KIDX_W'(KHALF) - k : k - KIDX_W'(KHALF);
    return d[TAP_W-1:0];
  endfunction

endpackage
`default_nettype wire

[design/gbr_ram.sv]
`default_nettype none
module gbr_ram #(
  parameter int DEPTH = 81,
  parameter int AW    = 7,
  parameter int DW    = 24
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[design/gbr_mac.sv]
`default_nettype none
module gbr_mac import gbr_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire mac_ctrl_t        ctrl,
  input  wire logic [RGB_W-1:0] pix,
  input  wire logic [WT_W-1:0]  wa,
  input  wire logic [WT_W-1:0]  wb,
  output logic                  busy,
  output logic      [RGB_W-1:0] res
);

  logic                      v1;
  logic                      v2;
  logic [RGB_W-1:0]          pix1;
  logic [2*WT_W-1:0]         wt1;
  logic [PIX_W+2*WT_W-1:0]   prod [3];
  logic [ACC_W-1:0]          acc  [3];

  // weight product, then pixel products, then accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= ctrl.valid;
      v2 <= v1;
    end
    pix1 <= pix;
    wt1  <= wa * wb;
    for (int c = 0; c < 3; c++) begin
      prod[c] <= pix1[c*PIX_W +: PIX_W] * wt1;
      if (ctrl.clr) begin
        acc[c] <= '0;
      end else if (v2) begin
        acc[c] <= acc[c] + ACC_W'(prod[c]);
      end
    end
  end

  assign busy = v1 | v2;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (acc[c][ACC_W-1:FRAC_W] > (ACC_W-FRAC_W)'(255)) begin
        res[c*PIX_W +: PIX_W] = '1;
      end else begin
        res[c*PIX_W +: PIX_W] = acc[c][FRAC_W +: PIX_W];
      end
    end
  end

endmodule
`default_nettype wire

[design/gaussian_blur_9x9_rgb_unit.sv]
`default_nettype none
// The input is ready only while idle, so one pixel is taken at a time; an interior
//   pixel's result word is offered after its taps are summed, a border pixel gives no word.
// The pace is set by the single read port of the line store (eight stored lines read per
//   pixel), the one shared MAC (81 taps per interior pixel) and any output stall; a result
//   word not yet taken holds the next interior pixel.
// Reset (rst, synchronous, active high) clears the FSM, counters, output valid and
//   loads the default sigma-3 weights and a 640x480 frame size.
module gaussian_blur_9x9_rgb_unit import gbr_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [RGB_W-1:0]   s_axis_tdata,   // blue_in, green_in, red_in
  input  wire logic [0:0]         s_axis_tuser,   // frame_start
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic      [RGB_W-1:0]   m_axis_tdata,   // blue_out, green_out, red_out
  output logic                    m_axis_tlast,   // frame_last
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int WW     = (CW + 1 > CFG_DIM_W) ? CW + 1 : CFG_DIM_W;
  localparam int LS_AW  = SLOT_W + CW;
  localparam int LS_DEP = STORE_LINES << CW;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_WR, S_WR2, S_MAC, S_DRAIN, S_RES
  } state_t;

  // Configuration registers
  logic [CFG_DIM_W-1:0] image_width;
  logic [CFG_DIM_W-1:0] image_height;
  logic [WT_W-1:0]      wts [5];
  logic                 cfg_wr;
  reg_idx_t             cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RST_WIDTH;
      image_height <= RST_HEIGHT;
      wts[0]       <= RST_W0;
      wts[1]       <= RST_W1;
      wts[2]       <= RST_W2;
      wts[3]       <= RST_W3;
      wts[4]       <= RST_W4;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_WIDTH:  image_width  <= pwdata[CFG_DIM_W-1:0];
        REG_HEIGHT: image_height <= pwdata[CFG_DIM_W-1:0];
        REG_W0:     wts[0]       <= pwdata[WT_W-1:0];
        REG_W1:     wts[1]       <= pwdata[WT_W-1:0];
        REG_W2:     wts[2]       <= pwdata[WT_W-1:0];
        REG_W3:     wts[3]       <= pwdata[WT_W-1:0];
        REG_W4:     wts[4]       <= pwdata[WT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_WIDTH:  prdata = PDATA_W'(image_width);
      REG_HEIGHT: prdata = PDATA_W'(image_height);
      REG_W0:     prdata = PDATA_W'(wts[0]);
      REG_W1:     prdata = PDATA_W'(wts[1]);
      REG_W2:     prdata = PDATA_W'(wts[2]);
      REG_W3:     prdata = PDATA_W'(wts[3]);
      REG_W4:     prdata = PDATA_W'(wts[4]);
      default:    prdata = '0;
    endcase
  end

  // Effective frame size: zero acts as one, clamp to storage and counter range
  logic [WW-1:0]    eff_w;
  logic [ROW_W:0]   eff_h;
  always_comb begin
    if (image_width == '0) begin
      eff_w = WW'(1);
    end else if (WW'(image_width) > WW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(image_width);
    end
    if (image_height == '0) begin
      eff_h = (ROW_W+1)'(1);
    end else if (image_height > CFG_DIM_W'(MAX_HEIGHT)) begin
      eff_h = (ROW_W+1)'(MAX_HEIGHT);
    end else begin
      eff_h = (ROW_W+1)'(image_height);
    end
  end

  // Position tracking
  logic [CW-1:0]    col_q, cur_col;
  logic [ROW_W-1:0] row_q, cur_row;
  logic [CW-1:0]    col_in;
  logic [ROW_W-1:0] row_in;
  logic [WW-1:0]    col_inc;
  logic [ROW_W:0]   row_inc;
  logic             s_acc;

  assign s_acc = s_axis_tvalid & s_axis_tready;

  always_comb begin
    col_in = s_axis_tuser[0] ? '0 : col_q;
    row_in = s_axis_tuser[0] ? '0 : row_q;
    if (WW'(col_in) >= eff_w) begin
      col_in = '0;
    end
    if ((ROW_W+1)'(row_in) >= eff_h) begin
      row_in = '0;
    end
    col_inc = WW'(col_in) + WW'(1);
    row_inc = (ROW_W+1)'(row_in) + (ROW_W+1)'(1);
  end

  // Memories
  logic                ls_we;
  logic [LS_AW-1:0]    ls_waddr, ls_raddr;
  logic [RGB_W-1:0]    ls_rdata;
  logic [RGB_W-1:0]    pix;
  logic                win_we;
  logic [WIN_AW-1:0]   win_waddr, win_raddr;
  logic [RGB_W-1:0]    win_wdata, win_rdata;

  gbr_ram #(.DEPTH(LS_DEP), .AW(LS_AW), .DW(RGB_W)) u_line_store (
    .clk  (clk),
    .we   (ls_we),
    .waddr(ls_waddr),
    .wdata(pix),
    .raddr(ls_raddr),
    .rdata(ls_rdata)
  );

  gbr_ram #(.DEPTH(WIN_DEPTH), .AW(WIN_AW), .DW(RGB_W)) u_window (
    .clk  (clk),
    .we   (win_we),
    .waddr(win_waddr),
    .wdata(win_wdata),
    .raddr(win_raddr),
    .rdata(win_rdata)
  );

  // Control
  state_t              state;
  logic [KIDX_W-1:0]   k_cnt;
  logic                rd_v;
  logic [SLOT_W-1:0]   rd_k;
  logic [KIDX_W-1:0]   wp;
  logic [KIDX_W-1:0]   mi, mj;
  logic                mac_issue;
  logic [TAP_W-1:0]    ti_r, tj_r;
  logic                interior, last_flag;
  mac_ctrl_t           mac_ctrl;
  logic                mac_busy;
  logic [RGB_W-1:0]    mac_res;
  logic [KIDX_W:0]     slot_sum;
  logic [KIDX_W-1:0]   mslot;
  logic                res_load;

  assign s_axis_tready = (state == S_IDLE);
  assign ls_raddr = {cur_row[SLOT_W-1:0] + k_cnt[SLOT_W-1:0], cur_col};
  assign ls_waddr = {cur_row[SLOT_W-1:0], cur_col};
  assign ls_we    = (state == S_WR);

  // column slot of kernel column mj: oldest column sits at wp
  assign slot_sum = (KIDX_W+1)'(wp) + (KIDX_W+1)'(mj);
  assign mslot    = (slot_sum >= (KIDX_W+1)'(KSIZE)) ?
                    KIDX_W'(slot_sum - (KIDX_W+1)'(KSIZE)) : KIDX_W'(slot_sum);
  assign win_raddr = WIN_AW'(mi) * WIN_AW'(KSIZE) + WIN_AW'(mslot);

  always_comb begin
    win_we    = 1'b0;
    win_waddr = WIN_AW'(rd_k) * WIN_AW'(KSIZE) + WIN_AW'(wp);
    win_wdata = ls_rdata;
    if (rd_v) begin
      win_we = 1'b1;
    end else if (state == S_WR2) begin
      win_we    = 1'b1;
      win_waddr = WIN_AW'(STORE_LINES) * WIN_AW'(KSIZE) + WIN_AW'(wp);
      win_wdata = pix;
    end
  end

  assign mac_ctrl.clr   = (state == S_WR2);
  assign mac_ctrl.valid = mac_issue;

  gbr_mac u_mac (
    .clk (clk),
    .rst (rst),
    .ctrl(mac_ctrl),
    .pix (win_rdata),
    .wa  (wts[ti_r]),
    .wb  (wts[tj_r]),
    .busy(mac_busy),
    .res (mac_res)
  );

  assign res_load = (state == S_RES) && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      col_q         <= '0;
      row_q         <= '0;
      k_cnt         <= '0;
      rd_v          <= 1'b0;
      wp            <= '0;
      mac_issue     <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // line store data follows each read state; MAC taps follow each issue state
      rd_v      <= (state == S_RD);
      mac_issue <= (state == S_MAC);
      if (m_axis_tvalid && m_axis_tready && !res_load) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_acc) begin
            // latch pixel and advance the raster position
            pix       <= s_axis_tdata;
            cur_col   <= col_in;
            cur_row   <= row_in;
            interior  <= (col_in >= CW'(KSIZE-1)) && (row_in >= ROW_W'(KSIZE-1));
            last_flag <= (WW'(col_in) == eff_w - WW'(1)) &&
                         ((ROW_W+1)'(row_in) == eff_h - (ROW_W+1)'(1));
            if (col_inc >= eff_w) begin
              col_q <= '0;
              row_q <= (row_inc >= eff_h) ? '0 : row_inc[ROW_W-1:0];
            end else begin
              col_q <= col_inc[CW-1:0];
              row_q <= row_in;
            end
            k_cnt <= '0;
            state <= S_RD;
          end
        end
        S_RD: begin
          // read the eight stored lines of this column, oldest first
          rd_k  <= k_cnt[SLOT_W-1:0];
          k_cnt <= k_cnt + KIDX_W'(1);
          if (k_cnt == KIDX_W'(STORE_LINES-1)) begin
            state <= S_WR;
          end
        end
        S_WR: begin
          state <= S_WR2;
        end
        S_WR2: begin
          // newest column written at wp; oldest column moves to wp+1
          wp <= (wp == KIDX_W'(KSIZE-1)) ? '0 : wp + KIDX_W'(1);
          mi <= '0;
          mj <= '0;
          state <= interior ? S_MAC : S_IDLE;
        end
        S_MAC: begin
          ti_r      <= tap_of(mi);
          tj_r      <= tap_of(mj);
          if (mj == KIDX_W'(KSIZE-1)) begin
            mj <= '0;
            mi <= mi + KIDX_W'(1);
            if (mi == KIDX_W'(KSIZE-1)) begin
              state <= S_DRAIN;
            end
          end else begin
            mj <= mj + KIDX_W'(1);
          end
        end
        S_DRAIN: begin
          if (!mac_issue && !mac_busy) begin
            state <= S_RES;
          end
        end
        S_RES: begin
          if (res_load) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= mac_res;
            m_axis_tlast  <= last_flag;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_idle_mac_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!mac_busy && !mac_issue))
    else $error("MAC pipeline active while idle");

  a_result_interior: assert property (@(posedge clk) disable iff (rst)
    res_load |-> interior)
    else $error("result produced for border pixel");

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    s_acc |=> (WW'(cur_col) < eff_w))
    else $error("column out of frame");

  a_no_write_clash: assert property (@(posedge clk) disable iff (rst)
    (state == S_WR2) |-> !rd_v)
    else $error("window write port conflict");
`endif

endmodule
`default_nettype wire

[tb/gaussian_blur_9x9_rgb_unit_tb.sv]
module gaussian_blur_9x9_rgb_unit_tb;
  import gbr_pkg::*;

  typedef struct {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
    logic             last;
  } blur_word_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [RGB_W-1:0]   s_axis_tdata = '0;   // blue_in, green_in, red_in
  logic [0:0]         s_axis_tuser = '0;   // frame_start
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [RGB_W-1:0]   m_axis_tdata;        // blue_out, green_out, red_out
  logic               m_axis_tlast;        // frame_last
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  gaussian_blur_9x9_rgb_unit DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow copy of the block's registers and pixel counters
  logic [CFG_DIM_W-1:0] shadow_width  = RST_WIDTH;
  logic [CFG_DIM_W-1:0] shadow_height = RST_HEIGHT;
  logic [WT_W-1:0]      shadow_wt [0:KHALF] = '{RST_W0, RST_W1, RST_W2, RST_W3, RST_W4};
  int unsigned          cur_col = 0;
  int unsigned          cur_row = 0;
  // Pixels of the current frame, keyed by row*1024 + col
  logic [RGB_W-1:0]     frame_pix [int];

  blur_word_t blurred_q [$];
  int         mismatches = 0;
  int         idle_pct   = 0;
  int         stall_pct  = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #60_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Receiver back-pressure: stall at random per the current phase
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Compare each accepted result word with the oldest expected blur
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (blurred_q.size() == 0) begin
        $error("unexpected result word %h last %b", m_axis_tdata, m_axis_tlast);
        mismatches++;
      end else begin
        blur_word_t exp_w;
        exp_w = blurred_q.pop_front();
        if (m_axis_tdata[7:0] !== exp_w.blue) begin
          $error("blue_out expected %0d actual %0d", exp_w.blue, m_axis_tdata[7:0]);
          mismatches++;
        end
        if (m_axis_tdata[15:8] !== exp_w.green) begin
          $error("green_out expected %0d actual %0d", exp_w.green, m_axis_tdata[15:8]);
          mismatches++;
        end
        if (m_axis_tdata[23:16] !== exp_w.red) begin
          $error("red_out expected %0d actual %0d", exp_w.red, m_axis_tdata[23:16]);
          mismatches++;
        end
        if (m_axis_tlast !== exp_w.last) begin
          $error("frame_last expected %b actual %b", exp_w.last, m_axis_tlast);
          mismatches++;
        end
      end
    end
  end

  function automatic int unsigned clamp_dim(logic [CFG_DIM_W-1:0] v, int unsigned cap);
    if (v == 0) return 1;
    return (v > cap) ? cap : v;
  endfunction

  // Advance the pixel counters and queue the blur centered 4 rows and
  // 4 columns behind the accepted pixel, if it lies in the interior.
  function automatic void blur_pixel(logic [RGB_W-1:0] pix, logic fs);
    int unsigned w, h;
    logic [63:0] acc [0:2];
    logic [63:0] kw;
    logic [RGB_W-1:0] p;
    blur_word_t res;
    w = clamp_dim(shadow_width, DEF_MAX_WIDTH);
    h = clamp_dim(shadow_height, MAX_HEIGHT);
    if (fs) begin
      cur_col = 0;
      cur_row = 0;
    end
    if (cur_col >= w) cur_col = 0;
    if (cur_row >= h) cur_row = 0;
    frame_pix[cur_row * 1024 + cur_col] = pix;
    if (cur_row >= 8 && cur_col >= 8) begin
      acc = '{64'd0, 64'd0, 64'd0};
      for (int i = 0; i < KSIZE; i++) begin
        for (int j = 0; j < KSIZE; j++) begin
          kw = 64'(shadow_wt[i < KHALF ? KHALF - i : i - KHALF])
             * 64'(shadow_wt[j < KHALF ? KHALF - j : j - KHALF]);
          p = frame_pix[(cur_row - 8 + i) * 1024 + (cur_col - 8 + j)];
          for (int c = 0; c < 3; c++) acc[c] += 64'(p[8*c +: 8]) * kw;
        end
      end
      for (int c = 0; c < 3; c++) acc[c] = acc[c] >> FRAC_W;
      res.blue  = (acc[0] > 255) ? 8'hFF : acc[0][7:0];
      res.green = (acc[1] > 255) ? 8'hFF : acc[1][7:0];
      res.red   = (acc[2] > 255) ? 8'hFF : acc[2][7:0];
      res.last  = (cur_row == h - 1 && cur_col == w - 1);
      blurred_q.push_back(res);
    end
    cur_col++;
    if (cur_col >= w) begin
      cur_col = 0;
      cur_row++;
      if (cur_row >= h) cur_row = 0;
    end
  endfunction

  // Offer one pixel word; hold tvalid high after acceptance so back-to-back
  // words need no extra assignment in the same step.
  task automatic send_pixel(logic [RGB_W-1:0] pix, logic fs);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    s_axis_tuser  <= fs;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    blur_pixel(pix, fs);
  endtask

  // Drain outstanding results, then let the block finish any border pixel
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (blurred_q.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  // Setup phase and access phase, then deselect before the next transfer
  task automatic reg_write(reg_idx_t idx, logic [PDATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(idx) << 2;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_WIDTH:  shadow_width  = val[CFG_DIM_W-1:0];
      REG_HEIGHT: shadow_height = val[CFG_DIM_W-1:0];
      REG_W0:     shadow_wt[0]  = val[WT_W-1:0];
      REG_W1:     shadow_wt[1]  = val[WT_W-1:0];
      REG_W2:     shadow_wt[2]  = val[WT_W-1:0];
      REG_W3:     shadow_wt[3]  = val[WT_W-1:0];
      REG_W4:     shadow_wt[4]  = val[WT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_weights(logic [WT_W-1:0] w0, w1, w2, w3, w4);
    reg_write(REG_W0, PDATA_W'(w0));
    reg_write(REG_W1, PDATA_W'(w1));
    reg_write(REG_W2, PDATA_W'(w2));
    reg_write(REG_W3, PDATA_W'(w3));
    reg_write(REG_W4, PDATA_W'(w4));
  endtask

  // Send npix words of one frame; fill < 0 means random content
  task automatic send_frame(int npix, int fill, bit mark_start);
    logic [RGB_W-1:0] pix;
    for (int k = 0; k < npix; k++) begin
      pix = (fill < 0) ? RGB_W'($urandom) : RGB_W'(fill);
      send_pixel(pix, mark_start && k == 0);
    end
  endtask

  // Flat frames under default and all-ones weights, then random frames under zero and center-only weights
  task automatic test_flat_frames();
    reg_write(REG_WIDTH, 9);
    reg_write(REG_HEIGHT, 9);
    send_frame(81, 24'hFFFFFF, 1);
    settle();
    set_weights(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_frame(81, 24'h010203, 1);        // no channel saturates
    settle();
    set_weights(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_frame(81, -1, 1);
    settle();
    set_weights(16'h8000, 16'd0, 16'd0, 16'd0, 16'd0);    // center tap only
    send_frame(81, -1, 1);
    settle();
  endtask

  // Restart mid-frame and let frames wrap without frame_start
  task automatic test_frame_sequencing();
    set_weights(16'd10038, 16'd9496, 16'd8037, 16'd6088, 16'd4127);
    reg_write(REG_WIDTH, 10);
    reg_write(REG_HEIGHT, 11);
    send_frame(57, -1, 1);                // broken off by the next frame_start
    send_frame(110, -1, 1);
    send_frame(110, -1, 0);               // wraps into a new frame by itself
    send_frame(95, -1, 1);
    settle();
  endtask

  // Dimension extremes: clamped, degenerate and too small for any result
  task automatic test_dimension_limits();
    reg_write(REG_WIDTH, 2047);           // acts as MAX_WIDTH
    reg_write(REG_HEIGHT, 9);
    send_frame(24, -1, 1);
    settle();
    reg_write(REG_WIDTH, 9);
    reg_write(REG_HEIGHT, 2047);          // acts as 1024 lines
    send_frame(99, -1, 1);
    settle();
    reg_write(REG_WIDTH, 0);
    reg_write(REG_HEIGHT, 0);
    send_frame(20, -1, 1);
    settle();
    reg_write(REG_WIDTH, 8);
    reg_write(REG_HEIGHT, 1024);
    send_frame(90, -1, 1);
    settle();
    reg_write(REG_WIDTH, 1024);
    reg_write(REG_HEIGHT, 8);
    send_frame(40, -1, 1);
    settle();
  endtask

  // Random frames under one idling mix; mostly whole frames, some broken off
  task automatic test_random_phase(int idle, int stall, int items);
    int sent, w, h, n;
    idle_pct  = idle;
    stall_pct = stall;
    sent = 0;
    while (sent < items) begin
      w = $urandom_range(9, 13);
      h = $urandom_range(9, 12);
      reg_write(REG_WIDTH, w);
      reg_write(REG_HEIGHT, h);
      set_weights(WT_W'($urandom), WT_W'($urandom), WT_W'($urandom),
                  WT_W'($urandom), WT_W'($urandom));
      if ($urandom_range(3) == 0)
        set_weights(WT_W'($urandom_range(12000)), WT_W'($urandom_range(12000)),
                    WT_W'($urandom_range(9000)), WT_W'($urandom_range(7000)),
                    WT_W'($urandom_range(5000)));
      n = ($urandom_range(4) == 0) ? $urandom_range(1, w * h) : w * h;
      send_frame(n, -1, 1);
      sent += n;
      if ($urandom_range(2) == 0) begin
        send_frame(w * h, -1, 0);
        sent += w * h;
      end
      settle();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_flat_frames();
    test_frame_sequencing();
    test_dimension_limits();
    test_random_phase(0, 0, 60);
    test_random_phase(87, 0, 60);
    test_random_phase(0, 87, 60);
    test_random_phase(38, 38, 60);
    settle();
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
design/gbr_pkg.sv
design/gbr_ram.sv
design/gbr_mac.sv
design/gaussian_blur_9x9_rgb_unit.sv
tb/gaussian_blur_9x9_rgb_unit_tb.sv
